/* hdl/julia_escape_time_pixel_macros.svh */
// Assertion helpers used by the RTL file that checks itself.
`ifndef JULIA_ESCAPE_TIME_PIXEL_MACROS_SVH
`define JULIA_ESCAPE_TIME_PIXEL_MACROS_SVH

// Condition must hold in the same cycle as the trigger.
`define JETP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("jetp assertion failed");

// Condition must hold in the cycle after the trigger.
`define JETP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("jetp assertion failed");

`endif

/* hdl/jetp_pkg.sv */
`default_nettype none

package jetp_pkg;

  // Coordinate and fixed-point geometry.
  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 28;
  localparam int PIX_W      = 12;
  localparam int ZW         = FRAC_BITS + 4;
  localparam int PW         = 2 * ZW;
  localparam int ITER_W     = 10;
  localparam int CELLS      = 4;

  // Register field widths.
  localparam int XO_W   = 21;
  localparam int STEP_W = 31;
  localparam int C_W    = 32;
  localparam int THR_W  = 32;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Derived datapath widths.
  localparam int DIFF_W = ((COORD_BITS + 1 > XO_W) ? COORD_BITS + 1 : XO_W) + 1;
  localparam int PROD_W = DIFF_W + STEP_W + 1;
  localparam int SUM_W  = ((PW + 2 - FRAC_BITS > C_W + 1) ? PW + 2 - FRAC_BITS : C_W + 1) + 1;
  localparam int WIDE_W = (PROD_W > SUM_W) ? PROD_W : SUM_W;
  localparam int MAG_W  = (PW + 1 > THR_W + FRAC_BITS) ? PW + 1 : THR_W + FRAC_BITS;

  localparam logic signed [WIDE_W-1:0] Z_HI = (WIDE_W'(1) <<< (ZW - 1)) - WIDE_W'(1);
  localparam logic signed [WIDE_W-1:0] Z_LO = -Z_HI - WIDE_W'(1);

  // Register reset values.
  localparam logic signed [XO_W-1:0]  X_ORIGIN_RST = '0;
  localparam logic signed [XO_W-1:0]  Y_ORIGIN_RST = '0;
  localparam logic [STEP_W-1:0]       STEP_RST     = STEP_W'(1048576);
  localparam logic signed [C_W-1:0]   C_REAL_RST   = -32'sd200099842;
  localparam logic signed [C_W-1:0]   C_IMAG_RST   = 32'sd30335891;
  localparam logic [THR_W-1:0]        THR_RST      = 32'd403182518;
  localparam logic [ITER_W-1:0]       LIMIT_RST    = 10'd200;

  // Color constants.
  localparam logic [7:0] RED_MUL  = 8'd10;
  localparam logic [7:0] RED_BASE = 8'd50;
  localparam logic [7:0] FULL     = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_ORIGIN,
    REG_Y_ORIGIN,
    REG_PIXEL_STEP,
    REG_C_REAL,
    REG_C_IMAG,
    REG_ESCAPE_THRESHOLD,
    REG_ITERATION_LIMIT
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAP,
    ST_RUN,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       escaped;
  } color_out_t;

  typedef struct packed {
    logic signed [C_W-1:0] c_real;
    logic signed [C_W-1:0] c_imag;
    logic [THR_W-1:0]      thr;
    logic [ITER_W-1:0]     limit;
  } orbit_cfg_t;

  typedef struct packed {
    logic                 valid;
    logic                 done;
    logic                 escaped;
    logic [ITER_W-1:0]    iter;
    logic signed [ZW-1:0] zr;
    logic signed [ZW-1:0] zi;
  } token_t;

  // Saturate a wide signed value to the Q4.F range of a z component.
  function automatic logic signed [ZW-1:0] sat_z(input logic signed [WIDE_W-1:0] v);
    logic signed [ZW-1:0] r;
    if (v > Z_HI) begin
      r = ZW'(Z_HI);
    end else if (v < Z_LO) begin
      r = ZW'(Z_LO);
    end else begin
      r = ZW'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hdl/jetp_map.sv */
`default_nettype none

module jetp_map
  import jetp_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     load,
  input  wire pixel_in_t                pix,
  input  wire logic signed [XO_W-1:0]   x_origin,
  input  wire logic signed [XO_W-1:0]   y_origin,
  input  wire logic [STEP_W-1:0]        step,
  output logic signed [ZW-1:0]          zr0,
  output logic signed [ZW-1:0]          zi0
);

  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_i;

  // Only the low coordinate bits take part; the origin is a signed column/row.
  assign dx = $signed(DIFF_W'(pix.pixel_x[COORD_BITS-1:0])) - DIFF_W'(x_origin);
  assign dy = $signed(DIFF_W'(pix.pixel_y[COORD_BITS-1:0])) - DIFF_W'(y_origin);

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= PROD_W'(dx) * $signed({1'b0, step});
      prod_i <= PROD_W'(dy) * $signed({1'b0, step});
    end
  end

  assign zr0 = sat_z(WIDE_W'(prod_r));
  assign zi0 = sat_z(WIDE_W'(prod_i));

endmodule

`default_nettype wire

/* hdl/jetp_cell.sv */
`default_nettype none

module jetp_cell
  import jetp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire orbit_cfg_t cfg,
  input  wire token_t     tok_in,
  output token_t          tok_out
);

  logic                 s1_valid;
  logic [ITER_W-1:0]    s1_iter;
  logic signed [PW-1:0] pr2;
  logic signed [PW-1:0] pi2;
  logic signed [PW-1:0] prx;

  logic [MAG_W-1:0]         mag;
  logic [MAG_W-1:0]         bnd;
  logic signed [PW:0]       sq;
  logic signed [PW:0]       cx;
  logic signed [WIDE_W-1:0] r_sum;
  logic signed [WIDE_W-1:0] i_sum;
  logic                     esc;
  logic                     fin;
  token_t                   tok_next;

  // First register: the three products of the incoming point.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= tok_in.valid && !tok_in.done;
    end
  end

  always_ff @(posedge clk) begin
    s1_iter <= tok_in.iter;
    pr2     <= PW'(tok_in.zr) * PW'(tok_in.zr);
    pi2     <= PW'(tok_in.zi) * PW'(tok_in.zi);
    prx     <= PW'(tok_in.zr) * PW'(tok_in.zi);
  end

  // Second stage: test the point produced by the previous iteration, then
  // form the next point from the same squares.
  always_comb begin
    mag   = MAG_W'($unsigned(pr2)) + MAG_W'($unsigned(pi2));
    bnd   = MAG_W'(cfg.thr) << FRAC_BITS;
    sq    = (PW + 1)'(pr2) - (PW + 1)'(pi2);
    cx    = (PW + 1)'(prx) <<< 1;
    r_sum = WIDE_W'(sq >>> FRAC_BITS) + WIDE_W'(cfg.c_real);
    i_sum = WIDE_W'(cx >>> FRAC_BITS) + WIDE_W'(cfg.c_imag);
    esc   = (s1_iter != '0) && (mag > bnd);
    fin   = (s1_iter == cfg.limit);

    tok_next.valid   = s1_valid;
    tok_next.done    = esc || fin;
    tok_next.escaped = esc;
    tok_next.iter    = esc ? s1_iter - ITER_W'(1) : s1_iter + ITER_W'(1);
    tok_next.zr      = sat_z(r_sum);
    tok_next.zi      = sat_z(i_sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    tok_out.done    <= tok_next.done;
    tok_out.escaped <= tok_next.escaped;
    tok_out.iter    <= tok_next.iter;
    tok_out.zr      <= tok_next.zr;
    tok_out.zi      <= tok_next.zi;
  end

endmodule

`default_nettype wire

/* hdl/julia_escape_time_pixel.sv */
// Julia set escape-time pixel evaluator. Each input beat carries one pixel
// coordinate; the block maps it to z = (coordinate - origin) * pixel_step in
// Q4.28, iterates z = z*z + c up to iteration_limit times, and returns one
// output beat with the color (10i+50, i, 2i, 255) of the first iteration i
// after which |z|^2 exceeds escape_threshold, or white with escaped low when
// the orbit stays bounded. One pixel is evaluated at a time, and each
// iteration cell spends two register stages (multiply, then combine and
// test) on one iteration. A finished color sits in an output register, so
// the next pixel is taken while the previous result waits. Configuration
// writes are accepted every cycle and must only be issued while no pixel
// is in flight.

`default_nettype none
`include "julia_escape_time_pixel_macros.svh"

module julia_escape_time_pixel
  import jetp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,

  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire pixel_in_t             in_data,

  output logic                       out_valid,
  input  wire logic                  out_stall,
  output color_out_t                 out_data,

  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers.
  logic signed [XO_W-1:0] x_origin;
  logic signed [XO_W-1:0] y_origin;
  logic [STEP_W-1:0]      pixel_step;
  orbit_cfg_t             orbit_cfg;

  state_t state;
  state_t state_next;

  logic in_accept;
  logic inject;
  logic out_free;
  logic load_out;

  logic signed [ZW-1:0] zr0;
  logic signed [ZW-1:0] zi0;

  token_t           ring_in [CELLS];
  token_t           tok     [CELLS];
  logic [CELLS-1:0] live;
  logic             ring_done;
  token_t           ring_res;

  // Finished pixel waiting for the output register.
  logic              res_escaped;
  logic [ITER_W-1:0] res_iter;
  logic [7:0]        i8;

  // The configuration port never pushes back.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_origin         <= X_ORIGIN_RST;
      y_origin         <= Y_ORIGIN_RST;
      pixel_step       <= STEP_RST;
      orbit_cfg.c_real <= C_REAL_RST;
      orbit_cfg.c_imag <= C_IMAG_RST;
      orbit_cfg.thr    <= THR_RST;
      orbit_cfg.limit  <= LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_X_ORIGIN:         x_origin         <= cfg_data[XO_W-1:0];
        REG_Y_ORIGIN:         y_origin         <= cfg_data[XO_W-1:0];
        REG_PIXEL_STEP:       pixel_step       <= cfg_data[STEP_W-1:0];
        REG_C_REAL:           orbit_cfg.c_real <= cfg_data[C_W-1:0];
        REG_C_IMAG:           orbit_cfg.c_imag <= cfg_data[C_W-1:0];
        REG_ESCAPE_THRESHOLD: orbit_cfg.thr    <= cfg_data[THR_W-1:0];
        REG_ITERATION_LIMIT:  orbit_cfg.limit  <= cfg_data[ITER_W-1:0];
        default: begin
          // Writes past the register list are dropped.
        end
      endcase
    end
  end

  // Sequencer: IDLE takes a pixel, MAP holds the start-point products while
  // they are clamped and injected into the ring, RUN waits for a finished
  // token, and HOLD keeps the result until the output register frees.
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_accept) state_next = ST_MAP;
      ST_MAP:  state_next = ST_RUN;
      ST_RUN:  if (ring_done) state_next = ST_HOLD;
      ST_HOLD: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    inject   = 1'b0;
    load_out = 1'b0;
    unique case (state)
      ST_IDLE: in_stall = 1'b0;
      ST_MAP:  inject   = 1'b1;
      ST_RUN:  in_stall = 1'b1;
      ST_HOLD: load_out = out_free;
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  jetp_map u_map (
    .clk      (clk),
    .load     (in_accept),
    .pix      (in_data),
    .x_origin (x_origin),
    .y_origin (y_origin),
    .step     (pixel_step),
    .zr0      (zr0),
    .zi0      (zi0)
  );

  // Ring of iteration cells. The start token enters cell 0; afterwards the
  // token travels from each cell to the next, one iteration per cell, and the
  // last cell feeds cell 0 again. Finished tokens are ignored by the next cell.
  always_comb begin
    ring_in[0].valid   = inject;
    ring_in[0].done    = 1'b0;
    ring_in[0].escaped = 1'b0;
    ring_in[0].iter    = '0;
    ring_in[0].zr      = zr0;
    ring_in[0].zi      = zi0;
    if (!inject) begin
      ring_in[0] = tok[CELLS-1];
    end
    for (int c = 1; c < CELLS; c++) begin
      ring_in[c] = tok[c-1];
    end
  end

  for (genvar g = 0; g < CELLS; g++) begin : g_cell
    jetp_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .cfg     (orbit_cfg),
      .tok_in  (ring_in[g]),
      .tok_out (tok[g])
    );
  end

  // At most one token is in the ring, so the finished one is picked by a scan over the cells.
  always_comb begin
    ring_done = 1'b0;
    ring_res  = tok[0];
    for (int c = 0; c < CELLS; c++) begin
      live[c] = tok[c].valid;
      if (tok[c].valid && tok[c].done) begin
        ring_done = 1'b1;
        ring_res  = tok[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ring_done) begin
      res_escaped <= ring_res.escaped;
      res_iter    <= ring_res.iter;
    end
  end

  // Color of the escape iteration, red, green and blue wrapping at 256.
  assign i8 = res_iter[7:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data.alpha   <= FULL;
      out_data.escaped <= res_escaped;
      if (res_escaped) begin
        out_data.red   <= 8'(i8 * RED_MUL) + RED_BASE;
        out_data.green <= i8;
        out_data.blue  <= {i8[6:0], 1'b0};
      end else begin
        out_data.red   <= FULL;
        out_data.green <= FULL;
        out_data.blue  <= FULL;
      end
    end
  end

  // Only one pixel is ever in flight.
  `JETP_ASSERT_NOW(a_single_token, 1'b1, $onehot0(live))
  // A finished token can only appear while the sequencer waits for it.
  `JETP_ASSERT_NOW(a_done_in_run, ring_done, state == ST_RUN)
  // An accepted pixel always goes to the start-point stage next.
  `JETP_ASSERT_NEXT(a_accept_maps, in_accept, state == ST_MAP)
  // Nothing is left in the ring while a result waits for the output.
  `JETP_ASSERT_NOW(a_hold_empty, state == ST_HOLD, live == '0)

endmodule

`default_nettype wire
